>>> design/hsv_pkg.sv
`default_nettype none

package hsv_pkg;

    // Host limits
    localparam int MAX_HOST_CHARS  = 253;
    localparam int MAX_LABEL_CHARS = 63;

    localparam logic [7:0] HOST_LEN_MAX  = 8'(MAX_HOST_CHARS);
    localparam logic [6:0] LABEL_LEN_MAX = 7'(MAX_LABEL_CHARS);
    localparam logic [7:0] CHAR_COUNT_SAT = 8'd255;
    localparam logic [3:0] V6_GROUP_SAT   = 4'd15;
    localparam logic [3:0] V6_GROUPS_FULL = 4'd8;
    localparam logic [2:0] V4_DOTS_FULL   = 3'd3;
    localparam logic [1:0] V4_DIGITS_MAX  = 2'd3;
    localparam logic [2:0] V6_HEX_MAX     = 3'd4;
    localparam logic [9:0] OCTET_MAX      = 10'd255;
    localparam logic [7:0] BRACKET_MIN_LEN = 8'd4;

    // Character codes
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    // Colon run codes
    localparam logic [1:0] RUN_NONE   = 2'd0;
    localparam logic [1:0] RUN_SINGLE = 2'd1;
    localparam logic [1:0] RUN_DOUBLE = 2'd2;

    typedef enum logic [1:0] {
        KIND_DOMAIN = 2'd0,
        KIND_IPV4   = 2'd1,
        KIND_IPV6   = 2'd2
    } host_kind_t;

    typedef struct packed {
        logic [7:0] char_count;
        logic       bracket_mode;
        logic       first_is_digit;
        logic       colon_seen;
        logic       v4_good;
        logic [2:0] v4_octet_count;
        logic [1:0] v4_digit_count;
        logic [9:0] v4_octet_value;
        logic       v6_good;
        logic [3:0] v6_group_count;
        logic [2:0] v6_hex_count;
        logic       v6_double_seen;
        logic [1:0] v6_colon_run;
        logic       dn_good;
        logic [6:0] dn_label_len;
        logic       dn_prev_hyphen;
        logic       dn_has_letter;
    } hsv_state_t;

    localparam hsv_state_t STATE_RESET = '{
        char_count:     8'd0,
        bracket_mode:   1'b0,
        first_is_digit: 1'b0,
        colon_seen:     1'b0,
        v4_good:        1'b1,
        v4_octet_count: 3'd0,
        v4_digit_count: 2'd0,
        v4_octet_value: 10'd0,
        v6_good:        1'b1,
        v6_group_count: 4'd0,
        v6_hex_count:   3'd0,
        v6_double_seen: 1'b0,
        v6_colon_run:   RUN_NONE,
        dn_good:        1'b1,
        dn_label_len:   7'd0,
        dn_prev_hyphen: 1'b0,
        dn_has_letter:  1'b0
    };

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

endpackage

`default_nettype wire

>>> design/hsv_host_if.sv
`default_nettype none

interface hsv_host_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;
    logic       no_char;

    modport source (output valid, output ch, output last, output no_char, input ready);
    modport sink   (input valid, input ch, input last, input no_char, output ready);
endinterface

`default_nettype wire

>>> design/hsv_verdict_if.sv
`default_nettype none

interface hsv_verdict_if;
    logic       valid;
    logic       ready;
    logic       valid_res;
    logic [1:0] host_kind;

    modport source (output valid, output valid_res, output host_kind, input ready);
    modport sink   (input valid, input valid_res, input host_kind, output ready);
endinterface

`default_nettype wire

>>> design/hsv_recog.sv
`default_nettype none

module hsv_recog
    import hsv_pkg::*;
(
    input  hsv_state_t cur,
    input  logic [7:0] ch,
    input  logic       last,
    input  logic       no_char,
    output hsv_state_t nxt,
    output logic       ok,
    output host_kind_t kind
);

    hsv_state_t s;
    logic       first;
    logic       skip_v6;
    logic       v4_fin;
    logic       v6_fin;
    logic       dn_fin;
    logic [9:0] oct_next;

    always_comb
    begin
        s        = cur;
        first    = (cur.char_count == 8'd0);
        ok       = 1'b0;
        kind     = KIND_DOMAIN;
        oct_next = {cur.v4_octet_value[6:0], 3'b000} + {cur.v4_octet_value[8:0], 1'b0}
                 + {6'd0, ch[3:0]};

        if (first)
        begin
            s.bracket_mode   = (ch == CH_LBRACK);
            s.first_is_digit = is_dec(ch);
        end
        if (ch == CH_COLON)
            s.colon_seen = 1'b1;

        // IPv4 octets
        if (is_dec(ch))
        begin
            if (cur.v4_digit_count >= V4_DIGITS_MAX)
                s.v4_good = 1'b0;
            else
            begin
                if (cur.v4_digit_count == 2'd1 && cur.v4_octet_value == 10'd0)
                    s.v4_good = 1'b0;
                s.v4_octet_value = oct_next;
                s.v4_digit_count = cur.v4_digit_count + 2'd1;
                if (oct_next > OCTET_MAX)
                    s.v4_good = 1'b0;
            end
        end
        else if (ch == CH_DOT)
        begin
            if (cur.v4_digit_count == 2'd0 || cur.v4_octet_count >= V4_DOTS_FULL)
                s.v4_good = 1'b0;
            else
            begin
                s.v4_octet_count = cur.v4_octet_count + 3'd1;
                s.v4_digit_count = 2'd0;
                s.v4_octet_value = 10'd0;
            end
        end
        else
            s.v4_good = 1'b0;

        // LDH domain labels
        if (ch == CH_DOT)
        begin
            if (cur.dn_label_len == 7'd0 || cur.dn_prev_hyphen)
                s.dn_good = 1'b0;
            s.dn_label_len   = 7'd0;
            s.dn_prev_hyphen = 1'b0;
        end
        else if (is_letter(ch) || is_dec(ch) || ch == CH_HYPHEN)
        begin
            if (cur.dn_label_len >= LABEL_LEN_MAX)
                s.dn_good = 1'b0;
            else
            begin
                if (ch == CH_HYPHEN && cur.dn_label_len == 7'd0)
                    s.dn_good = 1'b0;
                s.dn_label_len   = cur.dn_label_len + 7'd1;
                s.dn_prev_hyphen = (ch == CH_HYPHEN);
                if (is_letter(ch))
                    s.dn_has_letter = 1'b1;
            end
        end
        else
            s.dn_good = 1'b0;

        // IPv6 groups; the brackets themselves bypass this recognizer
        skip_v6 = s.bracket_mode && (first || (last && ch == CH_RBRACK));
        if (!skip_v6)
        begin
            if (is_hex(ch))
            begin
                if (cur.v6_colon_run == RUN_SINGLE && cur.v6_group_count == 4'd0)
                    s.v6_good = 1'b0;
                if (cur.v6_hex_count >= V6_HEX_MAX)
                    s.v6_good = 1'b0;
                else
                begin
                    if (cur.v6_hex_count == 3'd0 && cur.v6_group_count < V6_GROUP_SAT)
                        s.v6_group_count = cur.v6_group_count + 4'd1;
                    s.v6_hex_count = cur.v6_hex_count + 3'd1;
                    s.v6_colon_run = RUN_NONE;
                end
            end
            else if (ch == CH_COLON)
            begin
                case (cur.v6_colon_run)
                    RUN_NONE:
                    begin
                        s.v6_colon_run = RUN_SINGLE;
                        s.v6_hex_count = 3'd0;
                    end
                    RUN_SINGLE:
                    begin
                        if (cur.v6_double_seen)
                            s.v6_good = 1'b0;
                        s.v6_double_seen = 1'b1;
                        s.v6_colon_run   = RUN_DOUBLE;
                    end
                    default:
                        s.v6_good = 1'b0;
                endcase
            end
            else
                s.v6_good = 1'b0;
        end

        if (cur.char_count != CHAR_COUNT_SAT)
            s.char_count = cur.char_count + 8'd1;

        // Verdicts on the updated state
        v4_fin = s.v4_good && (s.v4_octet_count == V4_DOTS_FULL) && (s.v4_digit_count != 2'd0);
        v6_fin = s.v6_good && (s.v6_colon_run != RUN_SINGLE)
              && (s.v6_double_seen ? (s.v6_group_count < V6_GROUPS_FULL)
                                   : (s.v6_group_count == V6_GROUPS_FULL));
        dn_fin = s.dn_good && !s.dn_prev_hyphen && s.dn_has_letter
              && (s.char_count <= HOST_LEN_MAX);

        if (s.bracket_mode)
        begin
            ok   = (s.char_count >= BRACKET_MIN_LEN) && (ch == CH_RBRACK) && v6_fin;
            kind = KIND_IPV6;
        end
        else if (s.first_is_digit && v4_fin)
        begin
            ok   = 1'b1;
            kind = KIND_IPV4;
        end
        else if (s.colon_seen)
        begin
            ok   = v6_fin;
            kind = KIND_IPV6;
        end
        else
        begin
            ok   = dn_fin;
            kind = KIND_DOMAIN;
        end

        if (no_char)
            ok = 1'b0;
        if (!ok)
            kind = KIND_DOMAIN;

        nxt = (last || no_char) ? STATE_RESET : s;
    end

endmodule

`default_nettype wire

>>> design/host_syntax_validator.sv
// Host name syntax checker: one host character per word, one verdict per host.
// The word that ends a host is held in the input register, then its verdict is loaded into
// the result register, from which it is offered.
// Throughput: one word per cycle; input stalls only while a finished verdict waits and
// the next one is ready to leave the recognizer stage.
// Reset (rst_n low, asynchronous): both stages empty, all recognizer state at its start values.
`default_nettype none

module host_syntax_validator
    import hsv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    hsv_host_if.sink      host,
    hsv_verdict_if.source verdict
);

    // Input register stage
    logic       s1_vld_reg;
    logic [7:0] s1_ch_reg;
    logic       s1_last_reg;
    logic       s1_none_reg;

    // Recognizer state carried between words of one host
    hsv_state_t state_reg;
    hsv_state_t state_next;

    // Result register stage
    logic       out_vld_reg;
    logic       out_ok_reg;
    host_kind_t out_kind_reg;

    logic       ok_next;
    host_kind_t kind_next;
    logic       s1_ends;
    logic       s1_adv;

    // A word that ends a host needs room in the result register; all others just pass.
    assign s1_ends    = s1_last_reg || s1_none_reg;
    assign s1_adv     = s1_vld_reg && (!s1_ends || !out_vld_reg || verdict.ready);
    assign host.ready = !s1_vld_reg || s1_adv;

    hsv_recog u_recog (
        .cur     (state_reg),
        .ch      (s1_ch_reg),
        .last    (s1_last_reg),
        .no_char (s1_none_reg),
        .nxt     (state_next),
        .ok      (ok_next),
        .kind    (kind_next)
    );

    // Capture the incoming word; hold it while the recognizer stage is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (host.ready)
            s1_vld_reg <= host.valid;
    end

    always_ff @(posedge clk)
    begin
        if (host.ready && host.valid)
        begin
            s1_ch_reg   <= host.ch;
            s1_last_reg <= host.last;
            s1_none_reg <= host.no_char;
        end
    end

    // Advance the recognizer state once per word; it returns to start after each verdict.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (s1_adv)
            state_reg <= state_next;
    end

    // Result register: load a verdict, drop it once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (s1_adv && s1_ends)
            out_vld_reg <= 1'b1;
        else if (verdict.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_ends)
        begin
            out_ok_reg   <= ok_next;
            out_kind_reg <= kind_next;
        end
    end

    assign verdict.valid     = out_vld_reg;
    assign verdict.valid_res = out_ok_reg;
    assign verdict.host_kind = out_kind_reg;

    // An invalid verdict always reports the domain code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_ok_reg) |-> (out_kind_reg == KIND_DOMAIN))
        else $error("invalid verdict with nonzero host kind");

    // After a verdict leaves the recognizer, the next host starts from clean state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_ends) |=> (state_reg == STATE_RESET))
        else $error("recognizer state not cleared after verdict");

    // A stalled word in the input register is neither lost nor changed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && !s1_adv) |=> (s1_vld_reg && $stable(s1_ch_reg) && $stable(s1_last_reg)))
        else $error("stalled word lost or overwritten");

    // Input backpressure only arises with both stages full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !host.ready |-> (s1_vld_reg && out_vld_reg && s1_ends))
        else $error("input stalled without a pending verdict");

endmodule

`default_nettype wire
